@@ sv/gcd_pkg.sv @@
// Shared types and constants for the great-circle distance block.
`default_nettype none
package gcd_pkg;

  // Datapath widths.
  localparam int CW       = 34;
  localparam int MAG_W    = 30;
  localparam int ROOT_W   = 31;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int RADIUS_W = 23;
  localparam int DIST_W   = 25;
  localparam int ATAN_N   = 32;

  // Request queue depth.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Fixed-point constants (angles in Q30 radians, degrees scaled by 2^23).
  localparam logic [31:0]        PI_Q30       = 32'd3373259426;
  localparam logic [29:0]        GAIN_Q30     = 30'd652032874;
  localparam logic [30:0]        DEG23_180    = 31'd1509949440;
  localparam logic [29:0]        DEG23_90     = 30'd754974720;
  localparam logic signed [29:0] LAT22_MAX    = 30'sd377487360;
  localparam logic [30:0]        Q30_ONE      = 31'd1073741824;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

  // Scaled reciprocal used to turn degrees into radians without a divider.
  localparam logic [63:0] RAD_RECIP = ({32'd0, PI_Q30} << 31) / 64'd1509949440;

  // Truncated Q30 arctangent of 2^-i.
  localparam logic [29:0] ATAN_Q30 [ATAN_N] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // One angle in degrees * 2^23 as sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } ang_t;

  // The four angles that one request needs.
  typedef struct packed {
    ang_t dlat;
    ang_t dlng;
    ang_t lat_a;
    ang_t lat_b;
  } req_t;

endpackage
`default_nettype wire

@@ sv/gcd_front.sv @@
// Front end: accepts point pairs, clamps, differences and reduces the angles.
`default_nettype none
module gcd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [29:0] lat_a,
  input  wire logic signed [30:0] lng_a,
  input  wire logic signed [29:0] lat_b,
  input  wire logic signed [30:0] lng_b,
  output logic                    req_valid,
  input  wire logic               req_ready,
  output gcd_pkg::req_t           req
);
  import gcd_pkg::*;

  // Saturate a latitude to +-90 degrees.
  function automatic logic signed [29:0] clamp_lat(logic signed [29:0] v);
    logic signed [29:0] r;
    if (v > LAT22_MAX) r = LAT22_MAX;
    else if (v < -LAT22_MAX) r = -LAT22_MAX;
    else r = v;
    return r;
  endfunction

  // Reduce a half difference modulo 180 degrees into [-90, 90).
  function automatic logic signed [32:0] reduce_half(logic signed [32:0] h);
    logic signed [32:0] dd;
    logic signed [32:0] hh;
    logic signed [32:0] r;
    dd = $signed({2'b00, DEG23_180});
    hh = $signed({3'b000, DEG23_90});
    if (h >= dd) r = h - dd;
    else if (h <= -dd) r = h + dd;
    else r = h;
    if (r >= hh) r = r - dd;
    else if (r < -hh) r = r + dd;
    return r;
  endfunction

  // Split into sign and magnitude.
  function automatic ang_t to_ang(logic signed [32:0] v);
    ang_t a;
    logic signed [32:0] m;
    m = (v < 0) ? -v : v;
    a.neg = (v < 0);
    a.mag = m[MAG_W-1:0];
    return a;
  endfunction

  logic signed [29:0] la;
  logic signed [29:0] lb;
  req_t               req_next;

  // Clamp the latitudes and form the request angles from the incoming pair.
  always_comb begin
    la = clamp_lat(lat_a);
    lb = clamp_lat(lat_b);
    req_next.dlat  = to_ang(reduce_half(33'(la) - 33'(lb)));
    req_next.dlng  = to_ang(reduce_half(33'(lng_a) - 33'(lng_b)));
    req_next.lat_a = to_ang(33'(la) <<< 1);
    req_next.lat_b = to_ang(33'(lb) <<< 1);
  end

  assign in_ready = !req_valid || req_ready;

  // Holding register toward the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= req_next;
    end
  end

  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> req_valid)
    else $error("accepted request did not reach the holding register");

endmodule
`default_nettype wire

@@ sv/gcd_queue.sv @@
// Short request queue between the front end and the compute pipeline.
`default_nettype none
module gcd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire gcd_pkg::req_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output gcd_pkg::req_t      pop_data
);
  import gcd_pkg::*;

  req_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] rd_ptr_next;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready  = (count != QCNT_W'(QDEPTH));
  assign pop_valid   = (count != '0);
  assign push        = push_valid && push_ready;
  assign pop         = pop_valid && pop_ready;
  assign rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage, with the head entry kept in a register for the consumer.
  // A request written into the slot that becomes the head is passed straight through.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (push && (wr_ptr == rd_ptr_next)) begin
      pop_data <= push_data;
    end else begin
      pop_data <= mem[rd_ptr_next];
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

@@ sv/gcd_cordic.sv @@
// Pipelined CORDIC, one register stage per iteration, rotation or vectoring.
`default_nettype none
module gcd_cordic #(
  parameter int STAGES = 24,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [gcd_pkg::CW-1:0] x_in,
  input  wire logic signed [gcd_pkg::CW-1:0] y_in,
  input  wire logic signed [gcd_pkg::CW-1:0] z_in,
  output logic signed [gcd_pkg::CW-1:0]      x_out,
  output logic signed [gcd_pkg::CW-1:0]      y_out,
  output logic signed [gcd_pkg::CW-1:0]      z_out
);
  import gcd_pkg::*;

  logic signed [CW-1:0] xs [STAGES+1];
  logic signed [CW-1:0] ys [STAGES+1];
  logic signed [CW-1:0] zs [STAGES+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  // One micro-rotation per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                 fwd;
    logic signed [CW-1:0] ang;
    assign fwd = VECTOR ? !(ys[i] > 0) : (zs[i] >= 0);
    assign ang = $signed({{(CW-30){1'b0}}, ATAN_Q30[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (fwd) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ang;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ang;
        end
      end
    end
  end

  assign x_out = xs[STAGES];
  assign y_out = ys[STAGES];
  assign z_out = zs[STAGES];

endmodule
`default_nettype wire

@@ sv/gcd_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module gcd_isqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [gcd_pkg::RAD_W-1:0]    radicand,
  output logic [gcd_pkg::ROOT_W-1:0]        root
);
  import gcd_pkg::*;

  logic [RAD_W-1:0]  rad [ROOT_W+1];
  logic [32:0]       rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];

  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  // Restoring digit step: bring down two bits, try 4*root+1.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [34:0] rem_ext;
    logic [34:0] trial;
    logic        ge;
    assign rem_ext = {rem[k], rad[k][RAD_W-1 -: 2]};
    assign trial   = {2'b00, rt[k], 2'b01};
    assign ge      = (rem_ext >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k] << 2;
        rem[k+1] <= ge ? 33'(rem_ext - trial) : rem_ext[32:0];
        rt[k+1]  <= {rt[k][ROOT_W-2:0], ge};
      end
    end
  end

  assign root = rt[ROOT_W];

endmodule
`default_nettype wire

@@ sv/gcd_back.sv @@
// Compute pipeline: radians, sines and cosines, haversine term, roots, angle, scale.
`default_nettype none
module gcd_back #(
  parameter int STAGES = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire gcd_pkg::req_t                  req,
  input  wire logic [gcd_pkg::RADIUS_W-1:0]   radius,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [gcd_pkg::DIST_W-1:0]          distance_m
);
  import gcd_pkg::*;

  // Pipeline depth from the queue pop to the last stage before the output.
  localparam int LAT = 4 + STAGES + 3 + ROOT_W + STAGES + 1;

  logic           en;
  logic [LAT-1:0] vld;
  ang_t           lane_in [4];

  assign en        = !out_valid || out_ready;
  assign req_ready = en;

  assign lane_in[0] = req.dlat;
  assign lane_in[1] = req.dlng;
  assign lane_in[2] = req.lat_a;
  assign lane_in[3] = req.lat_b;

  // Valid tracking for the whole pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], req_valid};
    end
  end

  // Degree to radian conversion: reciprocal estimate, then one correction.
  logic [61:0]          r1_p  [4];
  logic [62:0]          r1_e  [4];
  logic                 r1_neg[4];
  logic [61:0]          r2_n  [4];
  logic [30:0]          r2_q0 [4];
  logic                 r2_neg[4];
  logic [61:0]          r3_n  [4];
  logic [61:0]          r3_qd [4];
  logic [30:0]          r3_q0 [4];
  logic                 r3_neg[4];
  logic signed [CW-1:0] r4_z  [4];
  logic signed [CW-1:0] rx    [4];
  logic signed [CW-1:0] ry    [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [62:0] e_rnd;
    logic [61:0] rem;
    logic [30:0] q;
    assign e_rnd = r1_e[l] + {32'd0, 1'b1, 30'd0};
    assign rem   = r3_n[l] - r3_qd[l];
    assign q     = r3_q0[l] + 31'(rem >= {31'd0, DEG23_180});

    always_ff @(posedge clk) begin
      if (en) begin
        r1_p[l]   <= {32'd0, lane_in[l].mag} * {30'd0, PI_Q30};
        r1_e[l]   <= {33'd0, lane_in[l].mag} * {30'd0, RAD_RECIP[32:0]};
        r1_neg[l] <= lane_in[l].neg;
        r2_n[l]   <= r1_p[l] + {32'd0, DEG23_90};
        r2_q0[l]  <= e_rnd[61:31];
        r2_neg[l] <= r1_neg[l];
        r3_qd[l]  <= {31'd0, r2_q0[l]} * {31'd0, DEG23_180};
        r3_n[l]   <= r2_n[l];
        r3_q0[l]  <= r2_q0[l];
        r3_neg[l] <= r2_neg[l];
        r4_z[l]   <= r3_neg[l] ? -$signed({3'b000, q}) : $signed({3'b000, q});
      end
    end

    gcd_cordic #(.STAGES(STAGES), .VECTOR(1'b0)) u_rot (
      .clk  (clk),
      .en   (en),
      .x_in ($signed({{(CW-30){1'b0}}, GAIN_Q30})),
      .y_in ('0),
      .z_in (r4_z[l]),
      .x_out(rx[l]),
      .y_out(ry[l]),
      .z_out()
    );
  end

  // Q30 product rounded to nearest.
  function automatic logic signed [31:0] mul_q30(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

  // Haversine term a, clamped to [0, 1].
  logic signed [31:0] m1_s1sq;
  logic signed [31:0] m1_s2sq;
  logic signed [31:0] m1_cc;
  logic signed [31:0] m2_s1sq;
  logic signed [31:0] m2_t;
  logic [30:0]        m3_a;
  logic [30:0]        m3_b;
  logic signed [32:0] a_sum;
  logic [30:0]        a_clamp;

  assign a_sum = 33'(m2_s1sq) + 33'(m2_t);

  always_comb begin
    if (a_sum < 0) a_clamp = '0;
    else if (a_sum > $signed({2'b00, Q30_ONE})) a_clamp = Q30_ONE;
    else a_clamp = a_sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s1sq <= mul_q30(ry[0][31:0], ry[0][31:0]);
      m1_s2sq <= mul_q30(ry[1][31:0], ry[1][31:0]);
      m1_cc   <= mul_q30(rx[2][31:0], rx[3][31:0]);
      m2_s1sq <= m1_s1sq;
      m2_t    <= mul_q30(m1_s2sq, m1_cc);
      m3_a    <= a_clamp;
      m3_b    <= Q30_ONE - a_clamp;
    end
  end

  // Square roots of a and 1 - a.
  logic [ROOT_W-1:0] ys_root;
  logic [ROOT_W-1:0] xs_root;

  gcd_isqrt u_sqrt_a (
    .clk     (clk),
    .en      (en),
    .radicand({1'b0, m3_a, 30'd0}),
    .root    (ys_root)
  );

  gcd_isqrt u_sqrt_b (
    .clk     (clk),
    .en      (en),
    .radicand({1'b0, m3_b, 30'd0}),
    .root    (xs_root)
  );

  // Central half angle by vectoring.
  logic signed [CW-1:0] vz;

  gcd_cordic #(.STAGES(STAGES), .VECTOR(1'b1)) u_vec (
    .clk  (clk),
    .en   (en),
    .x_in ($signed({{(CW-ROOT_W){1'b0}}, xs_root})),
    .y_in ($signed({{(CW-ROOT_W){1'b0}}, ys_root})),
    .z_in ('0),
    .x_out(),
    .y_out(),
    .z_out(vz)
  );

  // Full central angle, negative values forced to zero.
  logic signed [CW:0] c_full;
  logic [31:0]        f1_c;
  logic [55:0]        d_full;

  assign c_full = (CW + 1)'(vz) <<< 1;
  assign d_full = {24'd0, f1_c} * {33'd0, radius} + 56'd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_c <= (c_full < 0) ? 32'd0 : c_full[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance_m <= d_full[54:30];
    end
  end

  a_pop_tracked: assert property (@(posedge clk) disable iff (rst)
    req_valid && en |=> vld[0])
    else $error("popped request not tracked in the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && out_valid)
    else $error("pipeline moved while the output was stalled");

endmodule
`default_nettype wire

@@ sv/great_circle_distance.sv @@
// Throughput: one point pair per cycle; the CORDIC and square-root pipelines
// advance together and stall as a whole only when the result is not taken.
// A four-entry request queue lets the input side keep going during such stalls.
// Reset (synchronous, active high) empties the pipeline and sets the radius
// to 6371000 meters.
`default_nettype none
module great_circle_distance #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [29:0]           lat_a,
  input  wire logic signed [30:0]           lng_a,
  input  wire logic signed [29:0]           lat_b,
  input  wire logic signed [30:0]           lng_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gcd_pkg::DIST_W-1:0]        distance_m,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gcd_pkg::RADIUS_W-1:0] cfg_data
);
  import gcd_pkg::*;

  logic [RADIUS_W-1:0] sphere_radius_m;
  logic                f_valid;
  logic                f_ready;
  req_t                f_req;
  logic                q_valid;
  logic                q_ready;
  req_t                q_req;

  // Radius register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius_m <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sphere_radius_m <= cfg_data;
    end
  end

  gcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .lat_a    (lat_a),
    .lng_a    (lng_a),
    .lat_b    (lat_b),
    .lng_b    (lng_b),
    .req_valid(f_valid),
    .req_ready(f_ready),
    .req      (f_req)
  );

  gcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_req),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_req)
  );

  gcd_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (q_req),
    .radius    (sphere_radius_m),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance_m(distance_m)
  );

endmodule
`default_nettype wire
